FILE: rtl/core/sso_pkg.sv
`default_nettype none

package sso_pkg;

   // Shared iterative unit sizing. The accumulator holds the widest product
   // (32-bit base times a 20-bit factor), and during division it holds the
   // partial remainder above the 32 dividend/quotient bits.
   localparam int ACC_W     = 52;
   localparam int OPB_W     = 20;
   localparam int DIV_STEPS = 32;
   localparam int STEP_W    = 6;

   // Increment arithmetic.
   localparam int VINC_W        = 36;
   localparam int INC_REF_BITS  = 32;
   localparam int FM_SHIFT      = 16;
   localparam int Q15_SHIFT     = 15;
   localparam logic [OPB_W-1:0] FM_UNITY   = 20'd65536;
   localparam logic [ACC_W-1:0] ROUND_HALF = 52'd16384;

   // Quarter-sine table generation constants (Q30).
   localparam logic [63:0] Q30_ONE     = 64'h0000_0000_4000_0000;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Configuration port.
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_INCREMENT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIXED_AMPLITUDE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FM_DEPTH        = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_ENABLES    = 2'd3;

   localparam logic [14:0] AMP_RESET = 15'h7FFF;

   // Bit positions in mode_enables.
   localparam int MODE_AMP_LEVEL   = 0;
   localparam int MODE_AMP_MOD     = 1;
   localparam int MODE_PHASE_MOD   = 2;
   localparam int MODE_FM_UNIPOLAR = 3;
   localparam int MODE_FM_BIPOLAR  = 4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INDEX,
      ST_LOOKUP,
      ST_KMUL,
      ST_FMUL,
      ST_DIV,
      ST_SMUL,
      ST_INCR,
      ST_AMUL,
      ST_DONE
   } sso_state_type;

   typedef enum logic {
      OP_MUL,
      OP_DIV
   } sso_op_type;

   typedef struct packed {
      logic       start;
      sso_op_type op;
      logic       round;
   } sso_cmd_type;

endpackage

`default_nettype wire

FILE: rtl/core/sso_iter_unit.sv
`default_nettype none

module sso_iter_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sso_pkg::sso_cmd_type      cmd,
   input  wire logic [sso_pkg::ACC_W-1:0] opa,
   input  wire logic [sso_pkg::OPB_W-1:0] opb,
   output logic                           done,
   output logic [sso_pkg::ACC_W-1:0]      result
);
   import sso_pkg::*;

   logic              busy_ff, busy_in;
   sso_op_type        op_ff, op_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]  mcand_ff, mcand_in;
   logic [OPB_W-1:0]  mplier_ff, mplier_in;
   logic [STEP_W-1:0] count_ff, count_in;

   logic [ACC_W-1:0]  add_a;
   logic [ACC_W-1:0]  add_b;
   logic              add_cin;
   logic [ACC_W:0]    sum;
   logic [OPB_W:0]    partial_rem;
   logic              rem_ge;

   // One adder serves both operations. Multiply adds the shifted
   // multiplicand when the current multiplier bit is set; divide subtracts
   // the divisor from the shifted partial remainder and keeps the carry as
   // the quotient bit.
   always_comb begin
      partial_rem = {acc_ff[ACC_W-1 -: OPB_W], acc_ff[DIV_STEPS-1]};
      case (op_ff)
         OP_DIV: begin
            add_a   = ACC_W'(partial_rem);
            add_b   = ~ACC_W'(mplier_ff);
            add_cin = 1'b1;
         end
         default: begin
            add_a   = acc_ff;
            add_b   = mplier_ff[0] ? mcand_ff : '0;
            add_cin = 1'b0;
         end
      endcase
      sum    = {1'b0, add_a} + {1'b0, add_b} + (ACC_W + 1)'(add_cin);
      rem_ge = sum[ACC_W];
   end

   assign done = busy_ff &&
                 (((op_ff == OP_MUL) && (mplier_ff == '0)) ||
                  ((op_ff == OP_DIV) && (count_ff == '0)));

   assign result = acc_ff;

   always_comb begin
      busy_in   = busy_ff;
      op_in     = op_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      count_in  = count_ff;
      if (cmd.start) begin
         busy_in   = 1'b1;
         op_in     = cmd.op;
         mcand_in  = opa;
         mplier_in = opb;
         count_in  = STEP_W'(DIV_STEPS);
         if (cmd.op == OP_DIV) begin
            acc_in = opa;
         end else begin
            acc_in = cmd.round ? ROUND_HALF : '0;
         end
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         if (op_ff == OP_DIV) begin
            acc_in = {(rem_ge ? sum[OPB_W-1:0] : partial_rem[OPB_W-1:0]),
                      acc_ff[DIV_STEPS-2:0], rem_ge};
            count_in = count_ff - 1'b1;
         end else begin
            acc_in    = sum[ACC_W-1:0];
            mcand_in  = {mcand_ff[ACC_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[OPB_W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      count_ff  <= count_in;
   end

endmodule

`default_nettype wire

FILE: rtl/core/sincos_shaped_oscillator.sv
`default_nettype none

// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  amplitude_level, amplitude_mod, phase_offset,
//                                            freq_scale, freq_mod
// rsp      out        rsp_valid / rsp_stall  sample
// csr      in         csr_write_enable       csr_index, csr_write_data
//
// One item is in flight at a time. The shared shift-add/subtract unit retires one
// multiplier bit or one quotient bit per cycle; a negative bipolar FM input costs a
// 32-step division.
// Synchronous reset clears phase, held increment, the handshakes and the configuration
// registers, which go to zero but for the fixed amplitude, which resets to 7FFF.
// A result waits in the output register while the next item is accepted and
// processed; the item then holds in its last step until the register frees.

module sincos_shaped_oscillator #(
   parameter int PHASE_BITS            = 32,
   parameter int QUARTER_TABLE_ENTRIES = 256,
   parameter int SAMPLE_BITS           = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [14:0]                       req_amplitude_level,
   input  wire logic signed [15:0]                req_amplitude_mod,
   input  wire logic signed [15:0]                req_phase_offset,
   input  wire logic [14:0]                       req_freq_scale,
   input  wire logic signed [15:0]                req_freq_mod,

   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]          rsp_sample,

   input  wire logic                              csr_write_enable,
   input  wire logic [sso_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [sso_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import sso_pkg::*;

   localparam int ADDR_W  = $clog2(QUARTER_TABLE_ENTRIES + 1);
   localparam int FRAC_W  = PHASE_BITS - 2;
   localparam int IDXP_W  = FRAC_W + ADDR_W;
   localparam int MAG_W   = SAMPLE_BITS - 1;
   localparam int SCALE_W = VINC_W + PHASE_BITS;
   localparam logic [ADDR_W-1:0] TAB_LAST   = ADDR_W'(QUARTER_TABLE_ENTRIES);
   localparam logic [MAG_W-1:0]  FULL_SCALE = '1;

   typedef logic [MAG_W-1:0] sine_tab_type [0:QUARTER_TABLE_ENTRIES];

   // Quarter sine, rounded to full scale, from a Horner-form Taylor series.
   function automatic sine_tab_type build_sine_tab();
      sine_tab_type tab;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  t;
      logic [63:0]  s;
      logic [63:0]  fs;
      logic [63:0]  ent;
      int           i;
      fs = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
      for (i = 0; i <= QUARTER_TABLE_ENTRIES; i++) begin
         x  = (HALF_PI_Q30 * 64'(i)) / 64'(QUARTER_TABLE_ENTRIES);
         x2 = (x * x) >> 30;
         t  = Q30_ONE;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
         s  = (x * t) >> 30;
         if (s > Q30_ONE) begin
            s = Q30_ONE;
         end
         ent    = (s * fs + (Q30_ONE >> 1)) >> 30;
         tab[i] = ent[MAG_W-1:0];
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

   // Control and architectural state.
   sso_state_type           state_ff, state_in;
   logic                    launched_ff, launched_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PHASE_BITS-1:0]   phase_ff, phase_in;
   logic [PHASE_BITS-1:0]   held_ff, held_in;
   logic [31:0]             base_ff, base_in;
   logic [14:0]             fixed_amp_ff, fixed_amp_in;
   logic [15:0]             fm_depth_ff, fm_depth_in;
   logic [4:0]              mode_ff, mode_in;

   // Per-item working registers.
   logic [14:0]             amp_ff, amp_in;
   logic [15:0]             absx_ff, absx_in;
   logic                    xneg_ff, xneg_in;
   logic [14:0]             scale_ff, scale_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [1:0]              quad_ff, quad_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic [OPB_W-1:0]        k_ff, k_in;
   logic [VINC_W-1:0]       vinc_ff, vinc_in;
   logic [SAMPLE_BITS-1:0]  sample_ff, sample_in;
   logic [SAMPLE_BITS-1:0]  rsp_sample_ff, rsp_sample_in;

   // Combinational helpers.
   logic                    req_accept;
   logic                    slot_free;
   logic                    unit_phase;
   sso_cmd_type             cmd;
   logic [ACC_W-1:0]        opa;
   logic [OPB_W-1:0]        opb;
   logic                    unit_done;
   logic [ACC_W-1:0]        unit_result;
   logic [OPB_W-1:0]        depth_x10;
   logic [OPB_W-1:0]        scale_x10;
   logic [OPB_W-1:0]        fm_factor;
   logic [15:0]             fm_bits;
   logic [14:0]             amp_sel;
   logic [IDXP_W-1:0]       idx_prod;
   logic [ADDR_W-1:0]       idx;
   logic [MAG_W-1:0]        entry;
   logic [SCALE_W-1:0]      scaled;
   logic [SAMPLE_BITS-1:0]  prod_ext;

   sso_iter_unit u_iter (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .opa    (opa),
      .opb    (opb),
      .done   (unit_done),
      .result (unit_result)
   );

   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign unit_phase = (state_ff == ST_KMUL) || (state_ff == ST_FMUL) ||
                       (state_ff == ST_DIV)  || (state_ff == ST_SMUL) ||
                       (state_ff == ST_AMUL);

   assign depth_x10 = OPB_W'({fm_depth_ff, 3'b000}) + OPB_W'({fm_depth_ff, 1'b0});
   assign scale_x10 = OPB_W'({scale_ff, 3'b000}) + OPB_W'({scale_ff, 1'b0});
   assign fm_factor = FM_UNITY + k_ff;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_INDEX;
            end
         end
         ST_INDEX: begin
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (mode_ff[MODE_FM_BIPOLAR]) begin
               state_in = (absx_ff == '0) ? ST_INCR : ST_KMUL;
            end else if (mode_ff[MODE_FM_UNIPOLAR]) begin
               // A zero scale keeps the previous increment.
               state_in = (scale_ff == '0) ? ST_AMUL : ST_SMUL;
            end else begin
               state_in = ST_INCR;
            end
         end
         ST_KMUL: begin
            if (unit_done) begin
               state_in = xneg_ff ? ST_DIV : ST_FMUL;
            end
         end
         ST_FMUL, ST_DIV, ST_SMUL: begin
            if (unit_done) begin
               state_in = ST_INCR;
            end
         end
         ST_INCR: begin
            state_in = ST_AMUL;
         end
         ST_AMUL: begin
            if (unit_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs: handshake and commands to the shared unit.
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      cmd       = '0;
      opa       = '0;
      opb       = '0;
      unique case (state_ff)
         ST_KMUL: begin
            opa = ACC_W'(depth_x10);
            opb = OPB_W'(absx_ff);
         end
         ST_FMUL: begin
            opa = ACC_W'(base_ff);
            opb = fm_factor;
         end
         ST_DIV: begin
            cmd.op = OP_DIV;
            opa    = ACC_W'({base_ff, {FM_SHIFT{1'b0}}});
            opb    = fm_factor;
         end
         ST_SMUL: begin
            opa = ACC_W'(base_ff);
            opb = scale_x10;
         end
         ST_AMUL: begin
            cmd.round = 1'b1;
            opa       = ACC_W'(mag_ff);
            opb       = OPB_W'(amp_ff);
         end
         default: begin
         end
      endcase
      cmd.start   = unit_phase && !launched_ff;
      launched_in = launched_ff;
      if (cmd.start) begin
         launched_in = 1'b1;
      end else if (unit_done) begin
         launched_in = 1'b0;
      end
   end

   // Datapath and configuration next values.
   always_comb begin
      phase_in      = phase_ff;
      held_in       = held_ff;
      base_in       = base_ff;
      fixed_amp_in  = fixed_amp_ff;
      fm_depth_in   = fm_depth_ff;
      mode_in       = mode_ff;
      amp_in        = amp_ff;
      absx_in       = absx_ff;
      xneg_in       = xneg_ff;
      scale_in      = scale_ff;
      addr_in       = addr_ff;
      quad_in       = quad_ff;
      mag_in        = mag_ff;
      k_in          = k_ff;
      vinc_in       = vinc_ff;
      sample_in     = sample_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      amp_sel = fixed_amp_ff;
      if (mode_ff[MODE_AMP_LEVEL]) begin
         amp_sel = req_amplitude_level;
      end
      if (mode_ff[MODE_AMP_MOD]) begin
         // (x + 1) / 2 in Q0.15.
         amp_sel = {~req_amplitude_mod[15], req_amplitude_mod[14:1]};
      end
      fm_bits = req_freq_mod;

      idx_prod = IDXP_W'(phase_ff[FRAC_W-1:0]) * IDXP_W'(QUARTER_TABLE_ENTRIES);
      idx      = idx_prod[IDXP_W-1:FRAC_W];
      entry    = SINE_TAB[addr_ff];

      scaled   = {vinc_ff, {PHASE_BITS{1'b0}}} >> INC_REF_BITS;
      prod_ext = {1'b0, unit_result[Q15_SHIFT +: MAG_W]};

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BASE_INCREMENT:  base_in      = csr_write_data;
            CSR_FIXED_AMPLITUDE: fixed_amp_in = csr_write_data[14:0];
            CSR_FM_DEPTH:        fm_depth_in  = csr_write_data[15:0];
            CSR_MODE_ENABLES:    mode_in      = csr_write_data[4:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               amp_in   = amp_sel;
               absx_in  = fm_bits[15] ? (~fm_bits + 16'd1) : fm_bits;
               xneg_in  = fm_bits[15];
               scale_in = req_freq_scale;
               if (mode_ff[MODE_PHASE_MOD]) begin
                  // Whole cycles of the offset drop out modulo one.
                  phase_in = phase_ff +
                             {req_phase_offset[14:0], {(PHASE_BITS - 15){1'b0}}};
               end
            end
         end
         ST_INDEX: begin
            quad_in = phase_ff[PHASE_BITS-1:PHASE_BITS-2];
            addr_in = phase_ff[PHASE_BITS-1] ? (TAB_LAST - idx) : idx;
         end
         ST_LOOKUP: begin
            // Middle quarters use the complement of the table value.
            mag_in  = (quad_ff[1] ^ quad_ff[0]) ? (FULL_SCALE - entry) : entry;
            vinc_in = VINC_W'(base_ff);
         end
         ST_KMUL: begin
            if (unit_done) begin
               k_in = unit_result[Q15_SHIFT +: OPB_W];
            end
         end
         ST_FMUL: begin
            if (unit_done) begin
               vinc_in = unit_result[FM_SHIFT +: VINC_W];
            end
         end
         ST_DIV: begin
            if (unit_done) begin
               vinc_in = VINC_W'(unit_result[DIV_STEPS-1:0]);
            end
         end
         ST_SMUL: begin
            if (unit_done) begin
               vinc_in = unit_result[Q15_SHIFT +: VINC_W];
            end
         end
         ST_INCR: begin
            // Rescale to phase units and saturate just below one cycle.
            held_in = (|scaled[SCALE_W-1:PHASE_BITS]) ? '1 : scaled[PHASE_BITS-1:0];
         end
         ST_AMUL: begin
            if (unit_done) begin
               sample_in = quad_ff[1] ? (~prod_ext + 1'b1) : prod_ext;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sample_ff;
               phase_in      = phase_ff + held_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= '0;
         held_ff      <= '0;
         base_ff      <= '0;
         fixed_amp_ff <= AMP_RESET;
         fm_depth_ff  <= '0;
         mode_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         held_ff      <= held_in;
         base_ff      <= base_in;
         fixed_amp_ff <= fixed_amp_in;
         fm_depth_ff  <= fm_depth_in;
         mode_ff      <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      amp_ff        <= amp_in;
      absx_ff       <= absx_in;
      xneg_ff       <= xneg_in;
      scale_ff      <= scale_in;
      addr_ff       <= addr_in;
      quad_ff       <= quad_in;
      mag_ff        <= mag_in;
      k_ff          <= k_in;
      vinc_ff       <= vinc_in;
      sample_ff     <= sample_in;
      rsp_sample_ff <= rsp_sample_in;
   end

endmodule

`default_nettype wire

FILE: tb/sincos_shaped_oscillator_test.sv
`timescale 1ns / 100ps

module sincos_shaped_oscillator_test;
   import sso_pkg::*;

   typedef struct packed {
      logic [31:0] base;
      logic [14:0] fixed_amp;
      logic [15:0] depth;
      logic [4:0]  mode;
   } osc_cfg_t;

   typedef struct packed {
      logic [14:0] amp_level;
      logic [15:0] amp_mod;
      logic [15:0] phase_off;
      logic [14:0] freq_scale;
      logic [15:0] freq_mod;
   } osc_item_t;

   typedef struct packed {
      osc_cfg_t    cfg;
      osc_item_t   item;
      logic        known;
      logic [15:0] sample;
   } directed_row_t;

   typedef enum int {STALL_NONE, STALL_COIN, STALL_HOLD, STALL_PERIODIC} stall_style_t;

   localparam int ITEM_W        = $bits(osc_item_t);
   localparam int FULL_SCALE    = 32767;
   localparam int DIRECTED_ROWS = 22;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 235;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 100;

   localparam logic [4:0] EN_AMP_LEVEL   = 5'd1 << MODE_AMP_LEVEL;
   localparam logic [4:0] EN_AMP_MOD     = 5'd1 << MODE_AMP_MOD;
   localparam logic [4:0] EN_PHASE_MOD   = 5'd1 << MODE_PHASE_MOD;
   localparam logic [4:0] EN_FM_UNIPOLAR = 5'd1 << MODE_FM_UNIPOLAR;
   localparam logic [4:0] EN_FM_BIPOLAR  = 5'd1 << MODE_FM_BIPOLAR;
   localparam logic [4:0] EN_ALL         = EN_AMP_LEVEL | EN_AMP_MOD | EN_PHASE_MOD |
                                           EN_FM_UNIPOLAR | EN_FM_BIPOLAR;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [14:0]            req_amplitude_level = '0;
   logic signed [15:0]     req_amplitude_mod = '0;
   logic signed [15:0]     req_phase_offset = '0;
   logic [14:0]            req_freq_scale = '0;
   logic signed [15:0]     req_freq_mod = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic signed [15:0]     rsp_sample;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_BASE_INCREMENT;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   // Oscillator state as the block should hold it.
   osc_cfg_t    active_cfg = '{32'd0, AMP_RESET, 16'd0, 5'd0};
   logic [31:0] osc_phase = '0;
   logic [31:0] held_step = '0;
   int          quarter_rom [0:256];

   logic [15:0] expected_samples [$];
   logic [15:0] wanted_sample;
   int          error_count = 0;
   int          idle_cycles = 0;

   stall_style_t stall_style = STALL_NONE;
   int           style_left = 0;
   int           hold_left = 0;
   int           stall_tick = 0;

   directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
      // Out of reset the phase is exactly zero, so the shape is zero.
      '{'{32'd0, 15'h7FFF, 16'd0, 5'd0},
        '{15'h0000, 16'h0000, 16'h0000, 15'h0000, 16'h0000}, 1'b1, 16'h0000},
      '{'{32'd0, 15'h7FFF, 16'd0, 5'd0},
        '{15'h7FFF, 16'h8000, 16'h7FFF, 15'h7FFF, 16'h8000}, 1'b1, 16'h0000},
      // A quarter-cycle offset lands on the peak of the second quarter.
      '{'{32'd0, 15'h7FFF, 16'd0, EN_PHASE_MOD},
        '{15'h0000, 16'h0000, 16'h2000, 15'h0000, 16'h0000}, 1'b1, 16'h7FFE},
      // An offset of minus one is a whole cycle and leaves the phase alone.
      '{'{32'd0, 15'h7FFF, 16'd0, EN_PHASE_MOD},
        '{15'h0000, 16'h0000, 16'h8000, 15'h0000, 16'h0000}, 1'b1, 16'h7FFE},
      '{'{32'd0, 15'h7FFF, 16'd0, EN_PHASE_MOD | EN_AMP_LEVEL},
        '{15'h0000, 16'h0000, 16'h0000, 15'h0000, 16'h0000}, 1'b1, 16'h0000},
      '{'{32'd0, 15'h7FFF, 16'd0, EN_PHASE_MOD | EN_AMP_LEVEL},
        '{15'h7FFF, 16'h0000, 16'h7FFF, 15'h0000, 16'h0000}, 1'b0, 16'h0000},
      // The AM input wins over the level input; minus one maps to zero.
      '{'{32'd0, 15'h7FFF, 16'd0, EN_AMP_LEVEL | EN_AMP_MOD},
        '{15'h7FFF, 16'h8000, 16'h0000, 15'h0000, 16'h0000}, 1'b1, 16'h0000},
      '{'{32'd0, 15'h7FFF, 16'd0, EN_AMP_MOD},
        '{15'h0000, 16'h7FFF, 16'h0000, 15'h0000, 16'h0000}, 1'b0, 16'h0000},
      '{'{32'd0, 15'h7FFF, 16'd0, EN_AMP_MOD},
        '{15'h0000, 16'h0000, 16'h0000, 15'h0000, 16'h0000}, 1'b0, 16'h0000},
      '{'{32'h8000_0000, 15'h7FFF, 16'd0, 5'd0},
        '{15'h0000, 16'h0000, 16'h0000, 15'h0000, 16'h0000}, 1'b0, 16'h0000},
      '{'{32'h1234_5678, 15'h4000, 16'd0, EN_FM_UNIPOLAR},
        '{15'h0000, 16'h0000, 16'h0000, 15'h7FFF, 16'h0000}, 1'b0, 16'h0000},
      // A zero scale keeps the last increment.
      '{'{32'h1234_5678, 15'h4000, 16'd0, EN_FM_UNIPOLAR},
        '{15'h0000, 16'h0000, 16'h0000, 15'h0000, 16'h0000}, 1'b0, 16'h0000},
      '{'{32'h8000_0000, 15'h4000, 16'd0, EN_FM_UNIPOLAR},
        '{15'h0000, 16'h0000, 16'h0000, 15'h7FFF, 16'h0000}, 1'b0, 16'h0000},
      '{'{32'h8000_0000, 15'h4000, 16'd0, EN_FM_UNIPOLAR},
        '{15'h0000, 16'h0000, 16'h0000, 15'h0001, 16'h0000}, 1'b0, 16'h0000},
      '{'{32'h8000_0000, 15'h7FFF, 16'hFFFF, EN_FM_BIPOLAR},
        '{15'h0000, 16'h0000, 16'h0000, 15'h0000, 16'h7FFF}, 1'b0, 16'h0000},
      '{'{32'h8000_0000, 15'h7FFF, 16'hFFFF, EN_FM_BIPOLAR},
        '{15'h0000, 16'h0000, 16'h0000, 15'h0000, 16'h8000}, 1'b0, 16'h0000},
      '{'{32'h8000_0000, 15'h7FFF, 16'hFFFF, EN_FM_BIPOLAR},
        '{15'h0000, 16'h0000, 16'h0000, 15'h0000, 16'h0000}, 1'b0, 16'h0000},
      '{'{32'h1234_5678, 15'h7FFF, 16'hFFFF, EN_FM_BIPOLAR | EN_FM_UNIPOLAR},
        '{15'h0000, 16'h0000, 16'h0000, 15'h0000, 16'hFFFF}, 1'b0, 16'h0000},
      '{'{32'h1234_5678, 15'h7FFF, 16'd0, EN_FM_BIPOLAR},
        '{15'h0000, 16'h0000, 16'h0000, 15'h0000, 16'h1234}, 1'b0, 16'h0000},
      '{'{32'h0ABC_DEF1, 15'h2AAA, 16'h5555, EN_ALL},
        '{15'h5555, 16'hAAAA, 16'h5555, 15'h2AAA, 16'hAAAA}, 1'b0, 16'h0000},
      // The new base must not disturb the held increment.
      '{'{32'h0100_0000, 15'h2AAA, 16'h5555, EN_FM_UNIPOLAR},
        '{15'h0000, 16'h0000, 16'h0000, 15'h0000, 16'h0000}, 1'b0, 16'h0000},
      '{'{32'd0, 15'h0000, 16'd0, 5'd0},
        '{15'h7FFF, 16'h7FFF, 16'h7FFF, 15'h7FFF, 16'h7FFF}, 1'b1, 16'h0000}
   };

   sincos_shaped_oscillator u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_amplitude_level (req_amplitude_level),
      .req_amplitude_mod   (req_amplitude_mod),
      .req_phase_offset    (req_phase_offset),
      .req_freq_scale      (req_freq_scale),
      .req_freq_mod        (req_freq_mod),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_sample          (rsp_sample),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Quarter-sine table from a nested Taylor series in Q30. The divisors are
   // (2m)(2m+1) for m from six down to one.
   initial begin : build_quarter_rom
      logic [63:0] x, x2, t, s;
      for (int i = 0; i <= 256; i++) begin
         x = (HALF_PI_Q30 * 64'(i)) / 64'd256;
         x2 = (x * x) >> 30;
         t = Q30_ONE;
         for (int k = 0; k < 6; k++)
            t = Q30_ONE - ((x2 * t) >> 30) / 64'((12 - 2 * k) * (13 - 2 * k));
         s = (x * t) >> 30;
         if (s > Q30_ONE)
            s = Q30_ONE;
         quarter_rom[i] = int'((s * 64'(FULL_SCALE) + (Q30_ONE >> 1)) >> 30);
      end
   end

   function automatic logic [31:0] clamp_step(input logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   // Computes the sample for one item and moves the phase and held increment on.
   function automatic logic [15:0] advance_oscillator(input osc_item_t it);
      logic [14:0] amp;
      logic [31:0] step;
      logic [63:0] base, fm_mag, fm_gain;
      logic [31:0] mag, prod;
      logic [7:0]  idx;
      int          shape;
      amp = active_cfg.fixed_amp;
      step = held_step;
      base = 64'(active_cfg.base);
      if (active_cfg.mode[MODE_AMP_LEVEL])
         amp = it.amp_level;
      // (x + 1) / 2 of a Q1.15 value is its offset-binary form shifted right once.
      if (active_cfg.mode[MODE_AMP_MOD])
         amp = {~it.amp_mod[15], it.amp_mod[14:1]};
      if (active_cfg.mode[MODE_PHASE_MOD])
         osc_phase = osc_phase + {it.phase_off[14:0], 17'd0};

      if (active_cfg.mode[MODE_FM_BIPOLAR]) begin
         fm_mag = it.freq_mod[15] ? 64'h1_0000 - 64'(it.freq_mod) : 64'(it.freq_mod);
         fm_gain = 64'h1_0000 + ((fm_mag * 64'(active_cfg.depth) * 64'd10) >> 15);
         if (it.freq_mod == 16'd0)
            step = active_cfg.base;
         else if (!it.freq_mod[15])
            step = clamp_step((base * fm_gain) >> 16);
         else
            step = clamp_step((base << 16) / fm_gain);
      end else if (active_cfg.mode[MODE_FM_UNIPOLAR]) begin
         if (it.freq_scale != 15'd0)
            step = clamp_step((base * 64'(it.freq_scale) * 64'd10) >> 15);
      end else begin
         step = active_cfg.base;
      end
      held_step = step;

      idx = osc_phase[29:22];
      case (osc_phase[31:30])
         2'd0: shape = quarter_rom[idx];
         2'd1: shape = FULL_SCALE - quarter_rom[idx];
         2'd2: shape = -(FULL_SCALE - quarter_rom[256 - int'(idx)]);
         default: shape = -quarter_rom[256 - int'(idx)];
      endcase
      mag = (shape < 0) ? 32'(-shape) : 32'(shape);
      prod = (mag * 32'(amp) + 32'd16384) >> 15;
      osc_phase = osc_phase + step;
      return (shape < 0) ? 16'(32'd0 - prod) : prod[15:0];
   endfunction

   task automatic log_error(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      error_count++;
   endtask

   task automatic send_item(input osc_item_t it, input logic known, input logic [15:0] sample);
      logic [15:0] predicted;
      req_valid <= 1'b1;
      req_amplitude_level <= it.amp_level;
      req_amplitude_mod <= it.amp_mod;
      req_phase_offset <= it.phase_off;
      req_freq_scale <= it.freq_scale;
      req_freq_mod <= it.freq_mod;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predicted = advance_oscillator(it);
      expected_samples.push_back(known ? sample : predicted);
   endtask

   task automatic drain_samples();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0)
         @(posedge clock);
   endtask

   // Called only with the block idle; writes every register in turn.
   task automatic load_config(input osc_cfg_t c);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_BASE_INCREMENT;
      csr_write_data <= c.base;
      @(posedge clock);
      csr_index <= CSR_FIXED_AMPLITUDE;
      csr_write_data <= 32'(c.fixed_amp);
      @(posedge clock);
      csr_index <= CSR_FM_DEPTH;
      csr_write_data <= 32'(c.depth);
      @(posedge clock);
      csr_index <= CSR_MODE_ENABLES;
      csr_write_data <= 32'(c.mode);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_cfg = c;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            log_error($sformatf("sample %0d with no item outstanding", rsp_sample));
         end else begin
            wanted_sample = expected_samples.pop_front();
            if (rsp_sample !== wanted_sample)
               log_error($sformatf("sample %0d, expected %0d", rsp_sample,
                                   $signed(wanted_sample)));
         end
      end
   end

   always @(posedge clock) begin
      if (style_left == 0) begin
         stall_style <= stall_style_t'($urandom_range(0, 3));
         style_left <= $urandom_range(40, 400);
      end else begin
         style_left <= style_left - 1;
      end
      case (stall_style)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_COIN: rsp_stall <= 1'($urandom_range(0, 1));
         STALL_HOLD: begin
            if (hold_left == 0) begin
               rsp_stall <= ~rsp_stall;
               hold_left <= $urandom_range(1, 30);
            end else begin
               hold_left <= hold_left - 1;
            end
         end
         default: rsp_stall <= (stall_tick % 3) != 0;
      endcase
      stall_tick <= stall_tick + 1;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("no item moved for %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : run_stimulus
      osc_cfg_t  next_cfg;
      osc_item_t item;
      int        burst_left;
      bit        gapless;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (directed_rows[r].cfg != active_cfg) begin
            drain_samples();
            load_config(directed_rows[r].cfg);
         end
         send_item(directed_rows[r].item, directed_rows[r].known, directed_rows[r].sample);
      end
      drain_samples();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: next_cfg = '{32'h8000_0000, AMP_RESET, 16'hFFFF, EN_ALL};
            1: next_cfg = '{32'd0, 15'd0, 16'd0, EN_PHASE_MOD | EN_AMP_MOD};
            default: begin
               case ($urandom_range(0, 3))
                  0: next_cfg.base = $urandom_range(0, 1) ? 32'h8000_0000 : 32'd0;
                  1: next_cfg.base = $urandom_range(0, 32'h000F_FFFF);
                  default: next_cfg.base = $urandom_range(0, 32'h8000_0000);
               endcase
               next_cfg.fixed_amp = 15'($urandom);
               next_cfg.depth = 16'($urandom);
               next_cfg.mode = 5'($urandom);
            end
         endcase
         load_config(next_cfg);

         gapless = ($urandom_range(0, 3) == 0);
         burst_left = gapless ? PHASE_ITEMS + 1 : $urandom_range(1, 24);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            item = ITEM_W'({$urandom, $urandom, $urandom});
            case ($urandom_range(0, 15))
               0: item.amp_mod = 16'h8000;
               1: item.amp_mod = 16'h7FFF;
               2: item.freq_mod = 16'h8000;
               3: item.freq_mod = 16'h7FFF;
               4: item.freq_mod = 16'h0000;
               5: item.freq_scale = 15'h0000;
               6: item.freq_scale = 15'h7FFF;
               7: item.amp_level = 15'h0000;
               8: item.phase_off = 16'h0000;
               default: ;
            endcase
            send_item(item, 1'b0, 16'h0000);
            burst_left = burst_left - 1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if ($urandom_range(0, 19) == 0) begin
                  drain_samples();
               end else begin
                  req_valid <= 1'b0;
                  repeat ($urandom_range(1, 60)) @(posedge clock);
               end
            end
         end
         drain_samples();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_samples.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/sso_pkg.sv
rtl/core/sso_iter_unit.sv
rtl/core/sincos_shaped_oscillator.sv
tb/sincos_shaped_oscillator_test.sv
